@@ rtl/rpbe_pkg.sv @@
package rpbe_pkg;

  localparam int NUM_LANES = 3;

  typedef enum logic [2:0] {
    OP_MULTIPLY  = 3'd0,
    OP_SUBTRACT  = 3'd1,
    OP_SCREEN    = 3'd2,
    OP_OVERLAY   = 3'd3,
    OP_ADD       = 3'd4,
    OP_SCALE     = 3'd5,
    OP_REPLICATE = 3'd6,
    OP_COMBINE   = 3'd7
  } op_t;

  localparam logic [1:0] CH_RED   = 2'd0;
  localparam logic [1:0] CH_GREEN = 2'd1;
  localparam logic [1:0] CH_BLUE  = 2'd2;

  localparam logic [1:0] REG_OPERATION      = 2'd0;
  localparam logic [1:0] REG_CHANNEL_SELECT = 2'd1;
  localparam logic [1:0] REG_ADD_VALUE      = 2'd2;
  localparam logic [1:0] REG_SCALE_FACTOR   = 2'd3;

  typedef struct packed {
    op_t  op;
    logic hit;
  } lane_ctl_t;

endpackage

@@ rtl/rpbe_lane.sv @@
module rpbe_lane (
  input  logic                clk,
  input  logic                en,
  input  rpbe_pkg::lane_ctl_t ctl,
  input  logic [7:0]          a,
  input  logic [7:0]          b,
  input  logic [8:0]          add_value,
  input  logic [7:0]          scale_factor,
  output logic [7:0]          res,
  output logic [7:0]          a_q
);

  logic [7:0]          x;
  logic [7:0]          y;
  logic [15:0]         prod;
  logic [15:0]         prod_r;
  logic [7:0]          a_r;
  logic [7:0]          b_r;
  rpbe_pkg::lane_ctl_t ctl_r;

  // Pick multiplier operands; the single multiplier serves every product mode.
  always_comb begin
    unique case (ctl.op)
      rpbe_pkg::OP_SCREEN: begin
        x = ~a;
        y = ~b;
      end
      rpbe_pkg::OP_OVERLAY: begin
        x = b[7] ? ~a : a;
        y = b[7] ? ~b : b;
      end
      rpbe_pkg::OP_SCALE: begin
        x = a;
        y = scale_factor;
      end
      default: begin
        x = a;
        y = b;
      end
    endcase
  end

  assign prod = x * y;

  always_ff @(posedge clk) begin
    if (en) begin
      prod_r <= prod;
      a_r    <= a;
      b_r    <= b;
      ctl_r  <= ctl;
    end
  end

  // Round by 255: n = 255*q1 + r1, r1 = 255*q2 + r2, final fix on r2.
  logic [17:0]       n;
  logic [9:0]        q1;
  logic [9:0]        r1;
  logic [1:0]        q2;
  logic [8:0]        r2;
  logic [9:0]        q;
  logic [7:0]        q8;
  logic [7:0]        sub_v;
  logic signed [9:0] sum;
  logic [7:0]        add_v;
  logic [7:0]        scale_v;

  always_comb begin
    if (ctl_r.op == rpbe_pkg::OP_OVERLAY) begin
      n = {1'b0, prod_r, 1'b0} + 18'd127;
    end else begin
      n = {2'b00, prod_r} + 18'd127;
    end
    q1 = n[17:8];
    r1 = {2'b00, n[7:0]} + q1;
    q2 = r1[9:8];
    r2 = {1'b0, r1[7:0]} + {7'b0, q2};
    q  = q1 + {8'b0, q2} + {9'b0, (r2 >= 9'd255)};
    q8 = q[7:0];

    sub_v = (a_r > b_r) ? (a_r - b_r) : 8'd0;

    sum = $signed({2'b00, a_r}) + $signed({add_value[8], add_value});
    if (sum[9]) begin
      add_v = 8'd0;
    end else if (sum[8]) begin
      add_v = 8'd255;
    end else begin
      add_v = sum[7:0];
    end

    scale_v = (prod_r[15:8] != 8'd0) ? 8'd255 : prod_r[7:0];

    unique case (ctl_r.op)
      rpbe_pkg::OP_MULTIPLY: res = q8;
      rpbe_pkg::OP_SUBTRACT: res = sub_v;
      rpbe_pkg::OP_SCREEN:   res = 8'd255 - q8;
      rpbe_pkg::OP_OVERLAY:  res = b_r[7] ? (8'd255 - q8) : q8;
      rpbe_pkg::OP_ADD:      res = ctl_r.hit ? add_v : a_r;
      rpbe_pkg::OP_SCALE:    res = ctl_r.hit ? scale_v : a_r;
      default:               res = a_r;
    endcase
  end

  assign a_q = a_r;

endmodule

@@ rtl/rpbe_merge.sv @@
module rpbe_merge (
  input  logic                                   clk,
  input  logic                                   en,
  input  rpbe_pkg::op_t                          op,
  input  logic [1:0]                             sel,
  input  logic [rpbe_pkg::NUM_LANES-1:0][7:0]    lane_res,
  input  logic [rpbe_pkg::NUM_LANES-1:0][7:0]    first_q,
  input  logic [7:0]                             second_green_q,
  input  logic [7:0]                             third_blue_q,
  output logic [rpbe_pkg::NUM_LANES-1:0][7:0]    pix_r
);

  logic [rpbe_pkg::NUM_LANES-1:0][7:0] pix_nxt;

  always_comb begin
    pix_nxt = lane_res;
    unique case (op)
      rpbe_pkg::OP_REPLICATE: begin
        unique case (sel)
          rpbe_pkg::CH_RED:   pix_nxt = {3{first_q[0]}};
          rpbe_pkg::CH_GREEN: pix_nxt = {3{first_q[1]}};
          rpbe_pkg::CH_BLUE:  pix_nxt = {3{first_q[2]}};
          default:            pix_nxt = first_q;
        endcase
      end
      rpbe_pkg::OP_COMBINE: pix_nxt = {third_blue_q, second_green_q, first_q[0]};
      default:              pix_nxt = lane_res;
    endcase
  end

  // Output register: hold while the receiver stalls.
  always_ff @(posedge clk) begin
    if (en) begin
      pix_r <= pix_nxt;
    end
  end

endmodule

@@ rtl/rgb_pixel_blend_engine_unit.sv @@
// RGB pixel blend engine.
// Input channel (in_valid/in_ready): one request carries a working pixel,
// an operand pixel and a third blue byte. Output channel (out_valid/out_ready)
// returns one blended pixel per request, in order.
// Configuration: write operation, channel_select, add_value and scale_factor
// through cfg_we/cfg_index/cfg_wdata while no request is in flight.
// Throughput: one request per cycle while the receiver keeps out_ready high,
// set by the two-stage pipeline of three per-channel lanes, each with one
// 8x8 multiplier, followed by a merge stage with the output register.
// Stage one registers products and operands, stage two rounds, clamps and
// merges into the output register.
// Reset (rst_n low, synchronous) empties the pipeline and loads the register
// defaults: multiply, red, offset 0, scale 1.
// When the receiver stalls, the output register holds its pixel; stage one
// can still take one more request, after which in_ready drops.
module rgb_pixel_blend_engine_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       cfg_we,
  input  logic [1:0] cfg_index,
  input  logic [8:0] cfg_wdata,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_first_red,
  input  logic [7:0] in_first_green,
  input  logic [7:0] in_first_blue,
  input  logic [7:0] in_second_red,
  input  logic [7:0] in_second_green,
  input  logic [7:0] in_second_blue,
  input  logic [7:0] in_third_blue,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_red,
  output logic [7:0] out_green,
  output logic [7:0] out_blue
);

  rpbe_pkg::op_t op_r;
  logic [1:0]    sel_r;
  logic [8:0]    add_value_r;
  logic [7:0]    scale_factor_r;

  // Configuration registers; every two-bit index names one of them.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      op_r           <= rpbe_pkg::OP_MULTIPLY;
      sel_r          <= rpbe_pkg::CH_RED;
      add_value_r    <= 9'd0;
      scale_factor_r <= 8'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        rpbe_pkg::REG_OPERATION:      op_r           <= rpbe_pkg::op_t'(cfg_wdata[2:0]);
        rpbe_pkg::REG_CHANNEL_SELECT: sel_r          <= cfg_wdata[1:0];
        rpbe_pkg::REG_ADD_VALUE:      add_value_r    <= cfg_wdata;
        rpbe_pkg::REG_SCALE_FACTOR:   scale_factor_r <= cfg_wdata[7:0];
        default: ;
      endcase
    end
  end

  // Pipeline control: a stage advances when it is empty or its successor moves.
  logic v1_r;
  logic v2_r;
  logic en1;
  logic en2;

  assign en2      = !v2_r || out_ready;
  assign en1      = !v1_r || en2;
  assign in_ready = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_valid;
      if (en2) v2_r <= v1_r;
    end
  end

  logic [rpbe_pkg::NUM_LANES-1:0][7:0] first_pix;
  logic [rpbe_pkg::NUM_LANES-1:0][7:0] second_pix;
  logic [rpbe_pkg::NUM_LANES-1:0][7:0] lane_res;
  logic [rpbe_pkg::NUM_LANES-1:0][7:0] first_q;
  logic [rpbe_pkg::NUM_LANES-1:0][7:0] pix_r;
  logic [7:0]                          second_green_r;
  logic [7:0]                          third_blue_r;
  rpbe_pkg::op_t                       op_s1_r;
  logic [1:0]                          sel_s1_r;

  assign first_pix  = {in_first_blue, in_first_green, in_first_red};
  assign second_pix = {in_second_blue, in_second_green, in_second_red};

  // Stage one side data for the merge stage.
  always_ff @(posedge clk) begin
    if (en1) begin
      second_green_r <= in_second_green;
      third_blue_r   <= in_third_blue;
      op_s1_r        <= op_r;
      sel_s1_r       <= sel_r;
    end
  end

  // One lane per color channel.
  for (genvar i = 0; i < rpbe_pkg::NUM_LANES; i++) begin : g_lane
    rpbe_pkg::lane_ctl_t ctl;
    assign ctl = '{op: op_r, hit: (sel_r == 2'(i))};

    rpbe_lane u_lane (
      .clk          (clk),
      .en           (en1),
      .ctl          (ctl),
      .a            (first_pix[i]),
      .b            (second_pix[i]),
      .add_value    (add_value_r),
      .scale_factor (scale_factor_r),
      .res          (lane_res[i]),
      .a_q          (first_q[i])
    );
  end

  rpbe_merge u_merge (
    .clk            (clk),
    .en             (en2),
    .op             (op_s1_r),
    .sel            (sel_s1_r),
    .lane_res       (lane_res),
    .first_q        (first_q),
    .second_green_q (second_green_r),
    .third_blue_q   (third_blue_r),
    .pix_r          (pix_r)
  );

  assign out_valid = v2_r;
  assign out_red   = pix_r[0];
  assign out_green = pix_r[1];
  assign out_blue  = pix_r[2];

endmodule

@@ sim/testbench.sv @@
module testbench;

  // Channel code 3 selects no channel: the lane modes leave the pixel as is.
  localparam logic [1:0] CH_NONE = 2'd3;
  localparam int PIPE_DEPTH = 2;
  localparam int STALL_LIMIT = 2000;

  typedef struct packed {
    logic [7:0] first_red;
    logic [7:0] first_green;
    logic [7:0] first_blue;
    logic [7:0] second_red;
    logic [7:0] second_green;
    logic [7:0] second_blue;
    logic [7:0] third_blue;
  } blend_req_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
  } rgb_t;

  logic       clk;
  logic       rst_n = 1'b0;
  logic       cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [8:0] cfg_wdata = '0;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [7:0] in_first_red = '0;
  logic [7:0] in_first_green = '0;
  logic [7:0] in_first_blue = '0;
  logic [7:0] in_second_red = '0;
  logic [7:0] in_second_green = '0;
  logic [7:0] in_second_blue = '0;
  logic [7:0] in_third_blue = '0;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_red;
  logic [7:0] out_green;
  logic [7:0] out_blue;

  // Shadow copy of the mode registers, loaded with the reset defaults.
  rpbe_pkg::op_t     cur_op = rpbe_pkg::OP_MULTIPLY;
  logic [1:0]        cur_chan = rpbe_pkg::CH_RED;
  logic signed [8:0] cur_offset = '0;
  logic [7:0]        cur_scale = 8'd1;

  rgb_t blended_q[$];
  int   fail_count = 0;
  int   idle_cycles = 0;
  int   rx_hold = 0;
  bit   bubbles_on = 1'b1;

  rgb_pixel_blend_engine_unit i_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_first_red    (in_first_red),
    .in_first_green  (in_first_green),
    .in_first_blue   (in_first_blue),
    .in_second_red   (in_second_red),
    .in_second_green (in_second_green),
    .in_second_blue  (in_second_blue),
    .in_third_blue   (in_third_blue),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_red         (out_red),
    .out_green       (out_green),
    .out_blue        (out_blue)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // round(n/255) for n >= 0; 255 is odd, so a half never occurs.
  function automatic int nearest_255th(int n);
    return (n + 127) / 255;
  endfunction

  // Expected pixel for one request under the current mode registers.
  function automatic rgb_t blend_pixel(blend_req_t req);
    logic [7:0] a [3];
    logic [7:0] b [3];
    logic [7:0] r [3];
    int ia;
    int ib;
    int v;
    a = '{req.first_red, req.first_green, req.first_blue};
    b = '{req.second_red, req.second_green, req.second_blue};
    r = a;
    case (cur_op)
      rpbe_pkg::OP_MULTIPLY, rpbe_pkg::OP_SUBTRACT, rpbe_pkg::OP_SCREEN,
      rpbe_pkg::OP_OVERLAY: begin
        for (int i = 0; i < rpbe_pkg::NUM_LANES; i++) begin
          ia = int'(a[i]);
          ib = int'(b[i]);
          case (cur_op)
            rpbe_pkg::OP_MULTIPLY: v = nearest_255th(ia * ib);
            rpbe_pkg::OP_SUBTRACT: v = (ia > ib) ? ia - ib : 0;
            rpbe_pkg::OP_SCREEN:   v = 255 - nearest_255th((255 - ia) * (255 - ib));
            default: begin
              // Overlay: multiply form in the dark half, screen form above.
              if (ib <= 127) v = nearest_255th(2 * ia * ib);
              else v = 255 - nearest_255th(2 * (255 - ia) * (255 - ib));
            end
          endcase
          r[i] = 8'(v);
        end
      end
      rpbe_pkg::OP_ADD: begin
        if (cur_chan != CH_NONE) begin
          v = int'(a[cur_chan]) + int'(cur_offset);
          if (v < 0) v = 0;
          if (v > 255) v = 255;
          r[cur_chan] = 8'(v);
        end
      end
      rpbe_pkg::OP_SCALE: begin
        if (cur_chan != CH_NONE) begin
          v = int'(a[cur_chan]) * int'(cur_scale);
          if (v > 255) v = 255;
          r[cur_chan] = 8'(v);
        end
      end
      rpbe_pkg::OP_REPLICATE: begin
        if (cur_chan != CH_NONE) r = '{a[cur_chan], a[cur_chan], a[cur_chan]};
      end
      default: r = '{a[0], b[1], req.third_blue};
    endcase
    return rgb_t'{red: r[0], green: r[1], blue: r[2]};
  endfunction

  // Mostly no gap, sometimes a short one, rarely a long one.
  function automatic int pick_gap();
    int roll;
    if (!bubbles_on) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Bias toward the edges of the byte range and the overlay threshold.
  function automatic logic [7:0] rand_byte();
    case ($urandom_range(0, 9))
      0: return 8'd0;
      1: return 8'd255;
      2: return 8'd127;
      3: return 8'd128;
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function automatic blend_req_t rand_req();
    return blend_req_t'{first_red: rand_byte(), first_green: rand_byte(),
                        first_blue: rand_byte(), second_red: rand_byte(),
                        second_green: rand_byte(), second_blue: rand_byte(),
                        third_blue: rand_byte()};
  endfunction

  function automatic blend_req_t make_req(int fr, int fg, int fb, int sr, int sg,
                                          int sb, int tb);
    return blend_req_t'{first_red: 8'(fr), first_green: 8'(fg), first_blue: 8'(fb),
                        second_red: 8'(sr), second_green: 8'(sg),
                        second_blue: 8'(sb), third_blue: 8'(tb)};
  endfunction

  task automatic report_mismatch(string what, int got, int want);
    fail_count++;
    $display("tb: mismatch on %s: got %0d, want %0d", what, got, want);
  endtask

  // Present one request after a random gap, hold it until accepted, then
  // record the pixel it must produce. Valid stays high for a back-to-back
  // request; the next call lowers it only before a gap, and wait_idle lowers it.
  task automatic send_pixel(blend_req_t req);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_first_red    <= req.first_red;
    in_first_green  <= req.first_green;
    in_first_blue   <= req.first_blue;
    in_second_red   <= req.second_red;
    in_second_green <= req.second_green;
    in_second_blue  <= req.second_blue;
    in_third_blue   <= req.third_blue;
    do @(posedge clk); while (!in_ready);
    blended_q.push_back(blend_pixel(req));
  endtask

  // Drop valid and hold until every outstanding pixel has come back and the
  // pipeline has emptied.
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (blended_q.size() != 0) @(posedge clk);
    repeat (PIPE_DEPTH + 1) @(posedge clk);
  endtask

  // Leaves cfg_we high so writes can follow back to back; callers lower it.
  task automatic write_reg(logic [1:0] idx, logic [8:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    case (idx)
      rpbe_pkg::REG_OPERATION:      cur_op = rpbe_pkg::op_t'(data[2:0]);
      rpbe_pkg::REG_CHANNEL_SELECT: cur_chan = data[1:0];
      rpbe_pkg::REG_ADD_VALUE:      cur_offset = data;
      rpbe_pkg::REG_SCALE_FACTOR:   cur_scale = data[7:0];
      default: ;
    endcase
  endtask

  task automatic set_mode(rpbe_pkg::op_t op, logic [1:0] chan, int offset,
                          logic [7:0] scale);
    wait_idle();
    write_reg(rpbe_pkg::REG_OPERATION, 9'(op));
    write_reg(rpbe_pkg::REG_CHANNEL_SELECT, 9'(chan));
    write_reg(rpbe_pkg::REG_ADD_VALUE, 9'(offset));
    write_reg(rpbe_pkg::REG_SCALE_FACTOR, 9'(scale));
    cfg_we <= 1'b0;
  endtask

  // Multiply straight out of reset, then scale with the default factor of one
  // on the default red channel, which must pass the pixel through.
  task automatic test_reset_defaults();
    send_pixel(make_req(200, 100, 50, 128, 255, 0, 9));
    wait_idle();
    write_reg(rpbe_pkg::REG_OPERATION, 9'(rpbe_pkg::OP_SCALE));
    cfg_we <= 1'b0;
    send_pixel(make_req(200, 100, 50, 1, 2, 3, 4));
  endtask

  // Two-pixel modes at the byte extremes and on both sides of 127/128.
  task automatic test_blend_extremes();
    rpbe_pkg::op_t ops [4];
    ops = '{rpbe_pkg::OP_MULTIPLY, rpbe_pkg::OP_SUBTRACT, rpbe_pkg::OP_SCREEN,
            rpbe_pkg::OP_OVERLAY};
    foreach (ops[k]) begin
      set_mode(ops[k], rpbe_pkg::CH_RED, 0, 8'd1);
      send_pixel(make_req(255, 0, 128, 0, 255, 127, 0));
      send_pixel(make_req(0, 255, 255, 128, 255, 0, 255));
    end
  endtask

  task automatic test_lane_modes();
    set_mode(rpbe_pkg::OP_ADD, rpbe_pkg::CH_RED, 255, 8'd1);
    send_pixel(make_req(200, 10, 20, 0, 0, 0, 0));
    // Most negative offset drives blue to zero even from full scale.
    set_mode(rpbe_pkg::OP_ADD, rpbe_pkg::CH_BLUE, -256, 8'd1);
    send_pixel(make_req(1, 2, 255, 3, 4, 5, 6));
    set_mode(rpbe_pkg::OP_SCALE, rpbe_pkg::CH_GREEN, 0, 8'd0);
    send_pixel(make_req(9, 255, 7, 1, 1, 1, 1));
    set_mode(rpbe_pkg::OP_SCALE, rpbe_pkg::CH_BLUE, 0, 8'd255);
    send_pixel(make_req(9, 8, 1, 1, 1, 1, 1));
    send_pixel(make_req(9, 8, 0, 1, 1, 1, 1));
    set_mode(rpbe_pkg::OP_REPLICATE, rpbe_pkg::CH_GREEN, 0, 8'd1);
    send_pixel(make_req(11, 222, 33, 44, 55, 66, 77));
    set_mode(rpbe_pkg::OP_COMBINE, rpbe_pkg::CH_RED, 0, 8'd1);
    send_pixel(make_req(17, 34, 51, 68, 85, 102, 170));
  endtask

  // Channel code 3: every lane mode passes the first pixel through.
  task automatic test_unused_channel();
    set_mode(rpbe_pkg::OP_ADD, CH_NONE, 100, 8'd1);
    send_pixel(make_req(10, 20, 30, 40, 50, 60, 70));
    set_mode(rpbe_pkg::OP_SCALE, CH_NONE, 0, 8'd0);
    send_pixel(make_req(250, 5, 128, 1, 2, 3, 4));
    set_mode(rpbe_pkg::OP_REPLICATE, CH_NONE, -1, 8'd3);
    send_pixel(make_req(1, 128, 255, 9, 9, 9, 9));
  endtask

  // Random phases: each picks a mode (every operation in the first eight),
  // a pacing style, and streams random pixels.
  task automatic test_random_stream();
    rpbe_pkg::op_t op;
    logic [1:0]    chan;
    int            offset;
    logic [7:0]    scale;
    for (int phase = 0; phase < 22; phase++) begin
      op = (phase < 8) ? rpbe_pkg::op_t'(phase) : rpbe_pkg::op_t'($urandom_range(0, 7));
      chan = ($urandom_range(0, 99) < 15) ? CH_NONE : 2'($urandom_range(0, 2));
      case ($urandom_range(0, 5))
        0: offset = -256;
        1: offset = 255;
        2: offset = -255;
        default: offset = int'($urandom_range(0, 511)) - 256;
      endcase
      case ($urandom_range(0, 5))
        0: scale = 8'd0;
        1: scale = 8'd1;
        2: scale = 8'd255;
        3: scale = 8'($urandom_range(2, 4));
        default: scale = 8'($urandom_range(0, 255));
      endcase
      set_mode(op, chan, offset, scale);
      bubbles_on = ($urandom_range(0, 3) != 0);
      for (int n = 0; n < 25; n++) begin
        // Now and then hold the sender until the output side has caught up.
        if (n == 12 && $urandom_range(0, 3) == 0) wait_idle();
        send_pixel(rand_req());
      end
    end
    bubbles_on = 1'b1;
  endtask

  // Receiver: random stalls of random length, none while pacing is off.
  always @(posedge clk) begin
    int stall;
    if (rx_hold > 0) begin
      rx_hold   <= rx_hold - 1;
      out_ready <= 1'b0;
    end else begin
      stall = pick_gap();
      if (stall > 0) begin
        rx_hold   <= stall - 1;
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Compare each returned pixel against the oldest expectation.
  always @(posedge clk) begin
    rgb_t want;
    if (rst_n && out_valid && out_ready) begin
      if (blended_q.size() == 0) begin
        report_mismatch("unexpected pixel, red", int'(out_red), -1);
      end else begin
        want = blended_q.pop_front();
        if (out_red !== want.red) report_mismatch("red", int'(out_red), int'(want.red));
        if (out_green !== want.green)
          report_mismatch("green", int'(out_green), int'(want.green));
        if (out_blue !== want.blue) report_mismatch("blue", int'(out_blue), int'(want.blue));
      end
    end
  end

  // Watchdog: end the run when no request moves on either side for too long.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("tb: failure");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_defaults();
    test_blend_extremes();
    test_lane_modes();
    test_unused_channel();
    test_random_stream();
    wait_idle();
    repeat (PIPE_DEPTH + 5) @(posedge clk);
    if (fail_count == 0 && blended_q.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
